@@ design/spi_master_shifter_defines.svh @@
// Assertion macros for the SPI master shifter.
// Checks compile away when SYNTH is defined; no other dependencies.
`ifndef SPI_MASTER_SHIFTER_DEFINES_SVH
`define SPI_MASTER_SHIFTER_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, disabled during reset
`define SMS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spi_master_shifter check failed");
// Next-cycle implication, disabled during reset
`define SMS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spi_master_shifter check failed");
`else
`define SMS_ASSERT_NOW(lbl, ante, cons)
`define SMS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ design/spi_ms_pkg.sv @@
// Shared types and constants for the SPI master shifter.
// No dependencies; used by every module of the block.
package spi_ms_pkg;

  localparam int MAX_BITS        = 32;
  localparam int WORD_W          = 32;
  localparam int WORD_IDX_W      = $clog2(WORD_W);
  localparam int BITS_W          = $clog2(MAX_BITS + 1);
  localparam int BIT_COUNT_LIMIT = (MAX_BITS < 63) ? MAX_BITS : 63;
  localparam int HP_W            = 16;
  localparam int CFG_DATA_W      = 16;
  localparam int CFG_IDX_W       = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BIT_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_MODE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHARED_LINE = 2'd3;

  // Command opcodes
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CS    = 2'd2;

  localparam logic [BITS_W-1:0] BIT_COUNT_RESET   = BITS_W'(8);
  localparam logic [HP_W-1:0]   HALF_PERIOD_RESET = HP_W'(50);

  typedef enum logic [1:0] {
    OP_IDLE  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_CS    = 2'd3
  } op_t;

  typedef struct packed {
    logic [BITS_W-1:0] bit_count;
    logic              edge_mode;
    logic [HP_W-1:0]   half_period;
    logic              shared_line;
  } cfg_t;

  typedef struct packed {
    logic              cmd_valid;
    logic [1:0]        opcode;
    logic [WORD_W-1:0] cmd_data;
    logic              miso;
  } item_t;

  typedef struct packed {
    logic              sclk;
    logic              mosi;
    logic              cs_level;
    logic              data_drive;
    logic              busy_res;
    logic              done_res;
    logic [WORD_W-1:0] read_data;
  } res_t;

endpackage

@@ design/spi_master_shifter.sv @@
// SPI master shifter: one input transaction per system tick, one result each.
// A transaction is held in the input register, then passes through the tick logic into
// the result register, from which it is offered on out_.
// Throughput: one transaction per cycle while out_ does not stall; the tick sequencer
// updates its state once per transaction. Stalls on out_ back up into in_tready.
// Reset (rst_n low, synchronous): idle, pins high, registers at defaults.
`include "spi_master_shifter_defines.svh"

module spi_master_shifter (
  input  logic                              clk,
  input  logic                              rst_n,
  // Tick input
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [39:0]                       in_tdata,  // cmd_data[31:0], miso[32], zero pad
  input  logic [2:0]                        in_tuser,  // cmd_valid[0], opcode[2:1]
  // Tick result
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [39:0]                       out_tdata, // sclk[0], mosi[1], cs_level[2],
                                                       // data_drive[3], busy_res[4],
                                                       // done_res[5], read_data[37:6], pad
  // Register writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [spi_ms_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spi_ms_pkg::CFG_DATA_W-1:0] cfg_data
);

  spi_ms_pkg::cfg_t  cfg_s;
  spi_ms_pkg::item_t item_r;
  spi_ms_pkg::res_t  res_s;
  logic              in_valid_r;
  logic              out_valid_r;
  logic [39:0]       out_data_r;
  logic              step_en;

  assign cfg_ready = 1'b1;

  spi_ms_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg_s)
  );

  // Process the held tick when the result register can take it
  assign step_en   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || step_en;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.cmd_valid <= in_tuser[0];
      item_r.opcode    <= in_tuser[2:1];
      item_r.cmd_data  <= in_tdata[31:0];
      item_r.miso      <= in_tdata[32];
    end
  end

  spi_ms_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .cfg     (cfg_s),
    .item    (item_r),
    .res     (res_s)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_en) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_data_r <= {2'b00, res_s.read_data, res_s.done_res, res_s.busy_res,
                     res_s.data_drive, res_s.cs_level, res_s.mosi, res_s.sclk};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A completing tick never reports busy
  `SMS_ASSERT_NOW(a_done_not_busy, out_tvalid, !(out_tdata[5] && out_tdata[4]))
  // A full input stage facing a stalled result stage takes nothing new
  `SMS_ASSERT_NOW(a_stall_backpressure, in_valid_r && out_valid_r && !out_tready, !in_tready)
  // A zero bit count write is dropped
  `SMS_ASSERT_NEXT(a_bad_count_ignored,
    cfg_valid && cfg_index == spi_ms_pkg::REG_BIT_COUNT && cfg_data == '0,
    $stable(cfg_s.bit_count))

endmodule

@@ design/spi_ms_cfg.sv @@
// Configuration register file of the SPI master shifter.
// Depends on spi_ms_pkg.
module spi_ms_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                wr_en,
  input  logic [spi_ms_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [spi_ms_pkg::CFG_DATA_W-1:0]   wr_data,
  output spi_ms_pkg::cfg_t                    cfg
);

  spi_ms_pkg::cfg_t cfg_r;
  spi_ms_pkg::cfg_t cfg_nxt;
  logic             count_ok;

  // Accept only bit counts the shifter can handle
  assign count_ok = (wr_data >= spi_ms_pkg::CFG_DATA_W'(1)) &&
                    (wr_data <= spi_ms_pkg::CFG_DATA_W'(spi_ms_pkg::BIT_COUNT_LIMIT));

  // Decode a register write
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        spi_ms_pkg::REG_BIT_COUNT: begin
          if (count_ok) cfg_nxt.bit_count = wr_data[spi_ms_pkg::BITS_W-1:0];
        end
        spi_ms_pkg::REG_EDGE_MODE:   cfg_nxt.edge_mode   = wr_data[0];
        spi_ms_pkg::REG_HALF_PERIOD: cfg_nxt.half_period = wr_data[spi_ms_pkg::HP_W-1:0];
        spi_ms_pkg::REG_SHARED_LINE: cfg_nxt.shared_line = wr_data[0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bit_count   <= spi_ms_pkg::BIT_COUNT_RESET;
      cfg_r.edge_mode   <= 1'b0;
      cfg_r.half_period <= spi_ms_pkg::HALF_PERIOD_RESET;
      cfg_r.shared_line <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ design/spi_ms_core.sv @@
// Per-tick sequencer of the SPI master shifter: command start, half-period
// timing, pin levels, shift and sample. Depends on spi_ms_pkg.
module spi_ms_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_en,
  input  spi_ms_pkg::cfg_t   cfg,
  input  spi_ms_pkg::item_t  item,
  output spi_ms_pkg::res_t   res
);

  spi_ms_pkg::op_t                op_r, op_nxt;
  logic [spi_ms_pkg::WORD_W-1:0]  shift_r, shift_nxt;
  logic [spi_ms_pkg::WORD_W-1:0]  read_r, read_nxt;
  logic [spi_ms_pkg::BITS_W-1:0]  bits_r, bits_nxt;
  logic [spi_ms_pkg::HP_W-1:0]    tick_r, tick_nxt;
  logic [1:0]                     phase_r, phase_nxt;
  logic                           clk_lvl_r, clk_lvl_nxt;
  logic                           data_lvl_r, data_lvl_nxt;
  logic                           sel_lvl_r, sel_lvl_nxt;
  logic                           drv_lvl_r, drv_lvl_nxt;
  logic                           done;
  logic                           begin_half;
  logic                           finish;
  logic [spi_ms_pkg::BITS_W-1:0]  bit_idx;
  logic                           tx_bit;
  logic [spi_ms_pkg::HP_W-1:0]    phase_ticks;

  // Ticks left in a half-period after its first tick
  assign phase_ticks = (cfg.half_period == '0) ? '0 :
                       cfg.half_period - spi_ms_pkg::HP_W'(1);

  always_comb begin
    op_nxt       = op_r;
    shift_nxt    = shift_r;
    read_nxt     = read_r;
    bits_nxt     = bits_r;
    tick_nxt     = tick_r;
    phase_nxt    = phase_r;
    clk_lvl_nxt  = clk_lvl_r;
    data_lvl_nxt = data_lvl_r;
    sel_lvl_nxt  = sel_lvl_r;
    drv_lvl_nxt  = drv_lvl_r;
    done         = 1'b0;
    begin_half   = 1'b0;
    finish       = 1'b0;

    // Start a command, count down a half-period, or advance the phase or finish the command
    if (op_r == spi_ms_pkg::OP_IDLE) begin
      if (item.cmd_valid && item.opcode != 2'd3) begin
        phase_nxt  = 2'd0;
        begin_half = 1'b1;
        case (item.opcode)
          spi_ms_pkg::CMD_WRITE: begin
            op_nxt      = spi_ms_pkg::OP_WRITE;
            shift_nxt   = item.cmd_data;
            bits_nxt    = cfg.bit_count;
            drv_lvl_nxt = 1'b1;
          end
          spi_ms_pkg::CMD_READ: begin
            op_nxt   = spi_ms_pkg::OP_READ;
            read_nxt = '0;
            bits_nxt = cfg.bit_count;
            if (cfg.shared_line) begin
              data_lvl_nxt = 1'b0;
              drv_lvl_nxt  = 1'b0;
            end
          end
          default: begin
            op_nxt    = spi_ms_pkg::OP_CS;
            shift_nxt = spi_ms_pkg::WORD_W'(item.cmd_data[0]);
          end
        endcase
        if (op_nxt != spi_ms_pkg::OP_CS && bits_nxt == '0)
          bits_nxt = spi_ms_pkg::BITS_W'(1);
      end
    end else if (tick_r != '0) begin
      tick_nxt = tick_r - spi_ms_pkg::HP_W'(1);
    end else begin
      if (op_r == spi_ms_pkg::OP_CS) begin
        if (phase_r != 2'd3) phase_nxt = phase_r + 2'd1;
        else finish = 1'b1;
      end else if (phase_r == 2'd0) begin
        phase_nxt = 2'd1;
      end else begin
        bits_nxt = bits_r - spi_ms_pkg::BITS_W'(1);
        if (bits_nxt == '0) finish = 1'b1;
        else phase_nxt = 2'd0;
      end
      if (finish) begin
        op_nxt    = spi_ms_pkg::OP_IDLE;
        tick_nxt  = '0;
        phase_nxt = 2'd0;
        done      = 1'b1;
      end else begin
        begin_half = 1'b1;
      end
    end

    // Pin action at the start of a half-period; bits above the word shift out as zero
    bit_idx = bits_nxt - spi_ms_pkg::BITS_W'(1);
    tx_bit  = (int'(bit_idx) < spi_ms_pkg::WORD_W) ?
              shift_nxt[spi_ms_pkg::WORD_IDX_W'(bit_idx)] : 1'b0;
    if (begin_half) begin
      case (op_nxt)
        spi_ms_pkg::OP_WRITE: begin
          if (!cfg.edge_mode) begin
            if (phase_nxt == 2'd0) begin
              clk_lvl_nxt  = 1'b0;
              data_lvl_nxt = tx_bit;
            end else begin
              clk_lvl_nxt = 1'b1;
            end
          end else begin
            if (phase_nxt == 2'd0) begin
              clk_lvl_nxt = 1'b1;
            end else begin
              data_lvl_nxt = tx_bit;
              clk_lvl_nxt  = 1'b0;
            end
          end
        end
        spi_ms_pkg::OP_READ: begin
          if (phase_nxt == 2'd0) begin
            clk_lvl_nxt = 1'b0;
            read_nxt    = read_nxt | (spi_ms_pkg::WORD_W'(item.miso) << bit_idx);
          end else begin
            clk_lvl_nxt = 1'b1;
          end
        end
        spi_ms_pkg::OP_CS: begin
          if (phase_nxt == 2'd2) sel_lvl_nxt = shift_nxt[0];
        end
        default: clk_lvl_nxt = clk_lvl_r;
      endcase
      tick_nxt = phase_ticks;
    end
  end

  // Advance the state once per processed tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r       <= spi_ms_pkg::OP_IDLE;
      shift_r    <= '0;
      read_r     <= '0;
      bits_r     <= '0;
      tick_r     <= '0;
      phase_r    <= 2'd0;
      clk_lvl_r  <= 1'b1;
      data_lvl_r <= 1'b1;
      sel_lvl_r  <= 1'b1;
      drv_lvl_r  <= 1'b1;
    end else if (step_en) begin
      op_r       <= op_nxt;
      shift_r    <= shift_nxt;
      read_r     <= read_nxt;
      bits_r     <= bits_nxt;
      tick_r     <= tick_nxt;
      phase_r    <= phase_nxt;
      clk_lvl_r  <= clk_lvl_nxt;
      data_lvl_r <= data_lvl_nxt;
      sel_lvl_r  <= sel_lvl_nxt;
      drv_lvl_r  <= drv_lvl_nxt;
    end
  end

  // Result reflects the state after this tick
  always_comb begin
    res.sclk       = clk_lvl_nxt;
    res.mosi       = data_lvl_nxt;
    res.cs_level   = sel_lvl_nxt;
    res.data_drive = drv_lvl_nxt;
    res.busy_res   = (op_nxt != spi_ms_pkg::OP_IDLE);
    res.done_res   = done;
    res.read_data  = read_nxt;
  end

endmodule
